[src/luc_pkg.sv]
// Shared types, constants and register codes of the lens undistortion coordinate map.
package luc_pkg;

    // Image size that sets the inside test.
    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;

    // Pipeline shape: divider stages, quotient bits retired per stage, latencies.
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int MAP_LAT    = 10;
    localparam int PIPE_LAT   = DIV_LAT + MAP_LAT;

    // Fixed-point limits in Q.28.
    localparam logic [34:0]        R2_LIM  = 35'd1073741824;
    localparam logic signed [30:0] NORM_POS = 31'sd536870912;
    localparam logic signed [30:0] NORM_NEG = -31'sd536870912;
    localparam logic signed [39:0] Q28_ONE = 40'sd268435456;
    localparam logic signed [39:0] FAC_HI  = 40'sd2147483647;
    localparam logic signed [39:0] FAC_LO  = -40'sd2147483648;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_K1 = 4'd0,
        REG_K2 = 4'd1,
        REG_P1 = 4'd2,
        REG_P2 = 4'd3,
        REG_FX = 4'd4,
        REG_FY = 4'd5,
        REG_CX = 4'd6,
        REG_CY = 4'd7
    } luc_reg_t;

    // Configuration register file.
    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic [23:0]        fx;
        logic [23:0]        fy;
        logic [23:0]        cx;
        logic [23:0]        cy;
    } luc_cfg_t;

    localparam luc_cfg_t CFG_RESET = '{
        k1: -32'sd76076785,
        k2: 32'sd19853237,
        p1: 32'sd51966,
        p2: 32'sd4730,
        fx: 24'd1878647,
        fy: 24'd1873084,
        cx: 24'd1504113,
        cy: 24'd1017344
    };

    // One stage of the normalizing divider.
    typedef struct packed {
        logic [24:0] rem;
        logic [31:0] quo;
        logic [23:0] div;
        logic        neg;
        logic        sat;
        logic        zero;
    } luc_div_t;

endpackage

[src/luc_norm_div.sv]
// Pipelined normalizing divider: (coord*4096 - center) * 2^28 / focal, saturated to +-2.0.
module luc_norm_div
    import luc_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [11:0]        coord,
    input  logic [23:0]        center,
    input  logic [23:0]        focal,
    output logic signed [30:0] norm
);

    logic signed [24:0] diff;
    logic [23:0]        mag;
    luc_div_t           st_reg [0:DIV_STAGES];
    luc_div_t           st_next [0:DIV_STAGES-1];
    logic [28:0]        quo_mag;
    logic signed [30:0] norm_next;
    logic signed [30:0] norm_reg;

    // Offset from the principal point and its magnitude.
    always_comb begin
        diff = $signed({1'b0, coord, 12'd0}) - $signed({1'b0, center});
        mag  = diff[24] ? 24'(-diff) : diff[23:0];
    end

    // Entry stage: a quotient of 2.0 or more saturates, so only 29 bits are needed.
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rem  <= {1'b0, mag};
            st_reg[0].quo  <= '0;
            st_reg[0].div  <= focal;
            st_reg[0].neg  <= diff[24];
            st_reg[0].sat  <= {1'b0, mag} >= {focal, 1'b0};
            st_reg[0].zero <= diff == 25'sd0;
        end
    end

    // Restoring division stages, a few quotient bits each.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        always_comb begin
            logic        ge;
            logic [24:0] rn;
            st_next[k] = st_reg[k];
            for (int i = 0; i < DIV_STEPS; i++) begin
                ge = st_next[k].rem >= {1'b0, st_next[k].div};
                rn = ge ? st_next[k].rem - {1'b0, st_next[k].div} : st_next[k].rem;
                st_next[k].rem = {rn[23:0], 1'b0};
                st_next[k].quo = {st_next[k].quo[30:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= st_next[k];
            end
        end
    end

    // The quotient carries three extra fraction bits; drop them and apply the sign.
    always_comb begin
        quo_mag = st_reg[DIV_STAGES].quo[31:3];
        if (st_reg[DIV_STAGES].zero) begin
            norm_next = '0;
        end else if (st_reg[DIV_STAGES].sat) begin
            norm_next = st_reg[DIV_STAGES].neg ? NORM_NEG : NORM_POS;
        end else if (st_reg[DIV_STAGES].neg) begin
            norm_next = -$signed({2'b00, quo_mag});
        end else begin
            norm_next = $signed({2'b00, quo_mag});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

endmodule

[src/luc_distort.sv]
// Distortion pipeline: radial and tangential terms, mapping back to pixels, bounds test.
module luc_distort
    import luc_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  luc_cfg_t           cfg,
    input  logic signed [30:0] x,
    input  logic signed [30:0] y,
    output logic [11:0]        src_col,
    output logic [11:0]        src_row,
    output logic               in_image
);

    // Stage 1 products.
    logic signed [61:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [30:0] x1_reg, y1_reg;
    // Stage 2 squares and radius.
    logic signed [62:0] r2_sum;
    logic [30:0]        xx_reg, yy_reg, r2_reg;
    logic signed [31:0] xy_reg;
    logic signed [30:0] x2_reg, y2_reg;
    // Stage 3 products.
    logic [61:0]        r4f_reg;
    logic signed [62:0] k1r2_reg;
    logic signed [63:0] p1xy_reg, p2xy_reg;
    logic [31:0]        sx_reg, sy_reg;
    logic signed [30:0] x3_reg, y3_reg;
    // Stage 4.
    logic [32:0]        r4_reg;
    logic signed [34:0] k1t_reg;
    logic signed [36:0] t1x_reg, t1y_reg;
    logic signed [64:0] t3xf_reg, t3yf_reg;
    logic signed [30:0] x4_reg, y4_reg;
    // Stage 5.
    logic signed [65:0] k2r4_reg;
    logic signed [34:0] k1t5_reg;
    logic signed [37:0] tx_reg, ty_reg;
    logic signed [30:0] x5_reg, y5_reg;
    // Stage 6 radial factor.
    logic signed [39:0] fac_sum;
    logic signed [31:0] fac_reg;
    logic signed [37:0] tx6_reg, ty6_reg;
    logic signed [30:0] x6_reg, y6_reg;
    // Stage 7.
    logic signed [62:0] xf_reg, yf_reg;
    logic signed [37:0] tx7_reg, ty7_reg;
    // Stage 8.
    logic signed [38:0] xd_reg, yd_reg;
    // Stage 9.
    logic signed [63:0] um_reg, vm_reg;
    // Stage 10 output.
    logic signed [64:0] ud, vd;
    logic               in_next;
    logic [11:0]        col_reg, row_reg;
    logic               inside_reg;

    // Stage 1: squares and cross product of the normalized coordinate.
    always_ff @(posedge aclk) begin
        if (en) begin
            pxx_reg <= x * x;
            pyy_reg <= y * y;
            pxy_reg <= x * y;
            x1_reg  <= x;
            y1_reg  <= y;
        end
    end

    // Stage 2: scale back to Q.28 and clamp the radius at 4.0.
    assign r2_sum = pxx_reg + pyy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= pxx_reg[58:28];
            yy_reg <= pyy_reg[58:28];
            xy_reg <= pxy_reg[59:28];
            r2_reg <= (r2_sum[62:28] > R2_LIM) ? R2_LIM[30:0] : r2_sum[58:28];
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
        end
    end

    // Stage 3: r^4, k1 term, tangential cross terms and their radius sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            r4f_reg  <= r2_reg * r2_reg;
            k1r2_reg <= cfg.k1 * $signed({1'b0, r2_reg});
            p1xy_reg <= cfg.p1 * xy_reg;
            p2xy_reg <= cfg.p2 * xy_reg;
            sx_reg   <= {1'b0, r2_reg} + {xx_reg, 1'b0};
            sy_reg   <= {1'b0, r2_reg} + {yy_reg, 1'b0};
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
        end
    end

    // Stage 4: floor shifts, doubling folded into the shift, second tangential products.
    always_ff @(posedge aclk) begin
        if (en) begin
            r4_reg   <= r4f_reg[60:28];
            k1t_reg  <= k1r2_reg[62:28];
            t1x_reg  <= p1xy_reg[63:27];
            t1y_reg  <= p2xy_reg[63:27];
            t3xf_reg <= cfg.p2 * $signed({1'b0, sx_reg});
            t3yf_reg <= cfg.p1 * $signed({1'b0, sy_reg});
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
        end
    end

    // Stage 5: k2 term and the tangential sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            k2r4_reg <= cfg.k2 * $signed({1'b0, r4_reg});
            k1t5_reg <= k1t_reg;
            tx_reg   <= t1x_reg + $signed(t3xf_reg[64:28]);
            ty_reg   <= t1y_reg + $signed(t3yf_reg[64:28]);
            x5_reg   <= x4_reg;
            y5_reg   <= y4_reg;
        end
    end

    // Stage 6: radial factor, saturated to the signed 32-bit range.
    assign fac_sum = Q28_ONE + k1t5_reg + $signed(k2r4_reg[65:28]);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (fac_sum > FAC_HI) begin
                fac_reg <= FAC_HI[31:0];
            end else if (fac_sum < FAC_LO) begin
                fac_reg <= FAC_LO[31:0];
            end else begin
                fac_reg <= fac_sum[31:0];
            end
            tx6_reg <= tx_reg;
            ty6_reg <= ty_reg;
            x6_reg  <= x5_reg;
            y6_reg  <= y5_reg;
        end
    end

    // Stage 7: apply the radial factor.
    always_ff @(posedge aclk) begin
        if (en) begin
            xf_reg  <= x6_reg * fac_reg;
            yf_reg  <= y6_reg * fac_reg;
            tx7_reg <= tx6_reg;
            ty7_reg <= ty6_reg;
        end
    end

    // Stage 8: distorted normalized coordinate.
    always_ff @(posedge aclk) begin
        if (en) begin
            xd_reg <= $signed(xf_reg[62:28]) + tx7_reg;
            yd_reg <= $signed(yf_reg[62:28]) + ty7_reg;
        end
    end

    // Stage 9: scale by the focal lengths.
    always_ff @(posedge aclk) begin
        if (en) begin
            um_reg <= xd_reg * $signed({1'b0, cfg.fx});
            vm_reg <= yd_reg * $signed({1'b0, cfg.fy});
        end
    end

    // Stage 10: add the principal point in Q.40 and test the image bounds.
    always_comb begin
        ud = um_reg + $signed({1'b0, cfg.cx, 28'd0});
        vd = vm_reg + $signed({1'b0, cfg.cy, 28'd0});
        in_next = !ud[64] && !vd[64]
                  && (ud[63:40] < 24'(IMAGE_WIDTH))
                  && (vd[63:40] < 24'(IMAGE_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg    <= in_next ? ud[51:40] : 12'd0;
            row_reg    <= in_next ? vd[51:40] : 12'd0;
            inside_reg <= in_next;
        end
    end

    assign src_col  = col_reg;
    assign src_row  = row_reg;
    assign in_image = inside_reg;

endmodule

[src/lens_undistort_coordinate_map.sv]
// Top level of the lens undistortion coordinate map: registers, pipeline control, datapath.
//
// For each corrected-image pixel word on the s_ channel the block returns the
// source pixel of the distorted image on the m_ channel, with an inside flag.
// s_tdata holds out_col then out_row; m_tdata holds src_col then src_row and
// m_tuser holds inside_res. Outside points return coordinate zero.
// The configuration channel writes one register per handshake; cfg_ready is
// always high and indexes beyond the register list are dropped. Write it only
// while the pipeline is empty.
// Throughput is one word per clock while the output is not stalled. A word
// passes the normalizing divider (entry register, eight stages of four
// quotient bits each, output register) and then the multiply chain of the
// distortion model, whose last stage is the output register.
// When the receiver stalls a valid output word, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. Reset (aresetn low, synchronous)
// empties the pipeline and loads the default lens parameters.
module lens_undistort_coordinate_map
    import luc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] out_col, [23:12] out_row
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] src_col, [23:12] src_row
    output logic        m_tuser,   // [0] inside_res
    // Register writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    luc_cfg_t           cfg_reg;
    logic               en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic signed [30:0] norm_x, norm_y;
    logic [11:0]        src_col, src_row;
    logic               in_image;

    // Register file.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_K1:  cfg_reg.k1 <= cfg_data;
                REG_K2:  cfg_reg.k2 <= cfg_data;
                REG_P1:  cfg_reg.p1 <= cfg_data;
                REG_P2:  cfg_reg.p2 <= cfg_data;
                REG_FX:  cfg_reg.fx <= cfg_data[23:0];
                REG_FY:  cfg_reg.fy <= cfg_data[23:0];
                REG_CX:  cfg_reg.cx <= cfg_data[23:0];
                REG_CY:  cfg_reg.cy <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a finished word is waiting on the receiver.
    assign en       = !vld_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // Normalization of both axes.
    luc_norm_div u_div_x (
        .aclk   (aclk),
        .en     (en),
        .coord  (s_tdata[11:0]),
        .center (cfg_reg.cx),
        .focal  (cfg_reg.fx),
        .norm   (norm_x)
    );

    luc_norm_div u_div_y (
        .aclk   (aclk),
        .en     (en),
        .coord  (s_tdata[23:12]),
        .center (cfg_reg.cy),
        .focal  (cfg_reg.fy),
        .norm   (norm_y)
    );

    // Distortion model and bounds test.
    luc_distort u_distort (
        .aclk     (aclk),
        .en       (en),
        .cfg      (cfg_reg),
        .x        (norm_x),
        .y        (norm_y),
        .src_col  (src_col),
        .src_row  (src_row),
        .in_image (in_image)
    );

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tdata  = {src_row, src_col};
    assign m_tuser  = in_image;

`ifndef SYNTHESIS
    // An outside point carries a zero coordinate.
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("outside point with nonzero coordinate");

    // An inside point lies within the image.
    a_inside_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[11:0] < 12'(IMAGE_WIDTH - 1) + 12'd1
                                 || IMAGE_WIDTH == 4096)
                                && (m_tdata[23:12] < 12'(IMAGE_HEIGHT - 1) + 12'd1
                                    || IMAGE_HEIGHT == 4096))
        else $error("inside point beyond image bounds");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word right after reset");
`endif

endmodule

[bench/lens_undistort_coordinate_map_tb.sv]
// Self-checking testbench for the lens undistortion coordinate map.
`timescale 1ns / 1ps

module lens_undistort_coordinate_map_tb;
    import luc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // [11:0] out_col, [23:12] out_row
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [11:0] src_col, [23:12] src_row
    logic        m_tuser;          // [0] inside_res
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic        in_image;
    } src_pixel_t;

    src_pixel_t  pending_pixels[$];
    luc_cfg_t    lens;
    int          errors = 0;
    bit          quiet_sink = 1'b0;
    bit          quiet_source = 1'b0;
    bit          hold_sink = 1'b0;

    lens_undistort_coordinate_map dut (.*);

    always #4 aclk = ~aclk;

    // Floor division by 2^28 of a wide signed product.
    function automatic logic signed [127:0] fl28(input logic signed [127:0] v);
        return v >>> 28;
    endfunction

    function automatic logic signed [127:0] clip(input logic signed [127:0] v,
                                                 input logic signed [127:0] lo,
                                                 input logic signed [127:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Normalized coordinate in Q.28, quotient truncated toward zero.
    function automatic logic signed [127:0] norm_coord(input logic [11:0] c,
                                                       input logic [23:0] ctr,
                                                       input logic [23:0] foc);
        logic signed [127:0] d, q, lim;
        lim = 128'sd536870912;
        d = $signed({104'd0, c, 12'd0}) - $signed({104'd0, ctr});
        if (foc == 0) return d > 0 ? lim : (d < 0 ? -lim : 0);
        q = (d * 128'sd268435456) / $signed({104'd0, foc});
        return clip(q, -lim, lim);
    endfunction

    // Source pixel that a corrected pixel maps to under the current lens.
    function automatic src_pixel_t map_pixel(input logic [11:0] col,
                                             input logic [11:0] row);
        logic signed [127:0] x, y, xx, yy, xy, r2, r4, f, xd, yd, ud, vd;
        logic signed [127:0] k1, k2, p1, p2, fx, fy, cx, cy;
        src_pixel_t p;
        k1 = lens.k1; k2 = lens.k2; p1 = lens.p1; p2 = lens.p2;
        fx = $signed({104'd0, lens.fx}); fy = $signed({104'd0, lens.fy});
        cx = $signed({104'd0, lens.cx}); cy = $signed({104'd0, lens.cy});
        x = norm_coord(col, lens.cx, lens.fx);
        y = norm_coord(row, lens.cy, lens.fy);
        xx = fl28(x * x);
        yy = fl28(y * y);
        xy = fl28(x * y);
        r2 = clip(fl28(x * x + y * y), 0, 128'sd1073741824);
        r4 = fl28(r2 * r2);
        f = 128'sd268435456 + fl28(k1 * r2) + fl28(k2 * r4);
        f = clip(f, -128'sd2147483648, 128'sd2147483647);
        xd = fl28(x * f) + fl28(2 * p1 * xy) + fl28(p2 * (r2 + 2 * xx));
        yd = fl28(y * f) + fl28(2 * p2 * xy) + fl28(p1 * (r2 + 2 * yy));
        ud = xd * fx + (cx <<< 28);
        vd = yd * fy + (cy <<< 28);
        p = '0;
        if (ud >= 0 && vd >= 0
            && ud < (128'sd1024 <<< 40) && vd < (128'sd1024 <<< 40)) begin
            p.col = ud[51:40];
            p.row = vd[51:40];
            p.in_image = 1'b1;
        end
        return p;
    endfunction

    // Send one pixel word, with occasional random idle cycles.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        while (!quiet_source && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(map_pixel(col, row));
    endtask

    // Write one register while the pipeline is empty.
    task automatic write_reg(input luc_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_K1: lens.k1 = val;
            REG_K2: lens.k2 = val;
            REG_P1: lens.p1 = val;
            REG_P2: lens.p2 = val;
            REG_FX: lens.fx = val[23:0];
            REG_FY: lens.fy = val[23:0];
            REG_CX: lens.cx = val[23:0];
            REG_CY: lens.cy = val[23:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic load_lens(input luc_cfg_t c);
        write_reg(REG_K1, c.k1); write_reg(REG_K2, c.k2);
        write_reg(REG_P1, c.p1); write_reg(REG_P2, c.p2);
        write_reg(REG_FX, {8'd0, c.fx}); write_reg(REG_FY, {8'd0, c.fy});
        write_reg(REG_CX, {8'd0, c.cx}); write_reg(REG_CY, {8'd0, c.cy});
        cfg_valid <= 1'b0;
    endtask

    // Corners, the center and the largest coordinates under the reset lens.
    task automatic test_directed_corners();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd367, 12'd248);
        send_pixel(12'd1023, 12'd1023);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd2730, 12'd1365);
        drain_pipeline();
    endtask

    // Zero focal lengths, extreme coefficients, and an out-of-range index.
    task automatic test_lens_extremes();
        luc_cfg_t c;
        c = '{k1: 32'h7fffffff, k2: 32'h7fffffff, p1: 32'h80000000, p2: 32'h80000000,
              fx: 24'd0, fy: 24'd0, cx: 24'd0, cy: 24'hffffff};
        load_lens(c);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        drain_pipeline();
        c = '{k1: 32'h80000000, k2: 32'h80000000, p1: 32'h7fffffff, p2: 32'h7fffffff,
              fx: 24'hffffff, fy: 24'd1, cx: 24'hffffff, cy: 24'd0};
        load_lens(c);
        send_pixel(12'd4095, 12'd1);
        send_pixel(12'd100, 12'd0);
        send_pixel(12'd0, 12'd4095);
        drain_pipeline();
        // Index beyond the register list must be dropped.
        cfg_valid <= 1'b1;
        cfg_index <= 4'hf;
        cfg_data  <= 32'hffffffff;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        load_lens(CFG_RESET);
        send_pixel(12'd200, 12'd700);
        send_pixel(12'd800, 12'd100);
        drain_pipeline();
    endtask

    // Random pixels mostly inside the image, under the reset lens and three random lenses.
    task automatic test_random_lenses();
        luc_cfg_t c;
        for (int phase = 0; phase < 4; phase++) begin
            c = CFG_RESET;
            if (phase > 0) begin
                c.k1 = $urandom_range(1) ? $urandom()
                       : CFG_RESET.k1 + $signed($urandom_range(2**26) - 2**25);
                c.k2 = $urandom_range(1) ? $urandom()
                       : CFG_RESET.k2 + $signed($urandom_range(2**24) - 2**23);
                c.p1 = $urandom_range(3) == 0 ? $urandom() : $urandom_range(2**20);
                c.p2 = $urandom_range(3) == 0 ? $urandom() : $urandom_range(2**20);
                c.fx = $urandom_range(3) == 0 ? 24'($urandom())
                       : 24'($urandom_range(2**22) + 100000);
                c.fy = $urandom_range(3) == 0 ? 24'($urandom())
                       : 24'($urandom_range(2**22) + 100000);
                c.cx = 24'($urandom());
                c.cy = 24'($urandom());
            end
            load_lens(c);
            quiet_source = (phase == 1);
            quiet_sink   = (phase == 2);
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(9) < 8)
                    send_pixel(12'($urandom_range(1023)), 12'($urandom_range(1023)));
                else
                    send_pixel(12'($urandom()), 12'($urandom()));
            end
            quiet_source = 1'b0;
            quiet_sink   = 1'b0;
            drain_pipeline();
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        for (int n = 0; n < 60; n++)
            send_pixel(12'($urandom()), 12'($urandom()));
        drain_pipeline();
    endtask

    // Sink: random stalls, a long hold-off on request, a quiet stretch.
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                hold_sink = 1'b0;
                m_tready <= 1'b0;
                for (hold = 0; hold < 80; hold++) @(posedge aclk);
            end
            m_tready <= quiet_sink || $urandom_range(99) >= 6;
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        src_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word %h/%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[11:0] != want.col) begin
                    $display("%0t: src_col expected %0d actual %0d",
                             $time, want.col, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[23:12] != want.row) begin
                    $display("%0t: src_row expected %0d actual %0d",
                             $time, want.row, m_tdata[23:12]);
                    errors++;
                end
                if (m_tuser != want.in_image) begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.in_image, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("lens_undistort_coordinate_map test failed");
        $finish;
    end

    initial begin
        lens = CFG_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_lens_extremes();
        test_backpressure();
        test_random_lenses();
        if (errors == 0 && pending_pixels.size() == 0)
            $display("lens_undistort_coordinate_map test passed");
        else
            $display("lens_undistort_coordinate_map test failed");
        $finish;
    end
endmodule
